@@ hw/rtl/lss_pkg.sv @@
// lss_pkg: shared types and constants of the lifo stack with search
// opcodes, status codes, controller states and the memory request bundle
// no dependencies
`default_nettype none

package lss_pkg;

   localparam int DATA_W              = 32;
   localparam int COUNT_OUT_W         = 9;
   localparam int DEFAULT_STACK_DEPTH = 256;
   // widest address the depth range needs (65536 entries)
   localparam int MAX_ADDR_W          = 16;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [MAX_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]     wdata;
   } mem_req_type;

endpackage

`default_nettype wire

@@ hw/rtl/lss_if.sv @@
// lss_req_if, lss_rsp_if: valid/ready channels of the lifo stack
// depends on lss_pkg
`default_nettype none

interface lss_req_if
   import lss_pkg::*;
   ();
   logic               valid;
   logic               ready;
   op_type             opcode;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface lss_rsp_if
   import lss_pkg::*;
   ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic signed [31:0] data_out;
   logic               found;
   logic [8:0]         entry_count;
   logic signed [31:0] entry_sum;

   modport source (output valid, output status, output data_out, output found,
                   output entry_count, output entry_sum, input ready);
   modport sink   (input valid, input status, input data_out, input found,
                   input entry_count, input entry_sum, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lifo_stack_with_search.sv @@
// channel | dir | beat when          | payload
// req_bus | in  | valid && ready     | opcode, value
// rsp_bus | out | valid && ready     | status, data_out, found, entry_count, entry_sum
//
// one request at a time; push, refused requests and search on an empty stack pass from idle
// straight to the done state, pop and peek through the read state, other searches through
// the scan state, one store read per cycle from the top down, stopping at the first match.
// synchronous active-high reset clears count, sum and valids; no clearing pass.
// a held result keeps the request in flight in its done state, so the request after it stalls too.
// depends on lss_pkg, lss_if, lss_mem, lss_ctrl
`default_nettype none

module lifo_stack_with_search
   import lss_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   lss_req_if.sink   req_bus,
   lss_rsp_if.source rsp_bus
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;

   lss_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   lss_mem #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule

`default_nettype wire

@@ hw/rtl/lss_mem.sv @@
// lss_mem: single-port entry store with registered read data
// depends on lss_pkg
`default_nettype none

module lss_mem
   import lss_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  wire logic              clock,
   input  wire mem_req_type       mem_req,
   output      logic [DATA_W-1:0] rdata
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr[ADDR_W-1:0]] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem[mem_req.addr[ADDR_W-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lss_ctrl.sv @@
// lss_ctrl: request sequencer, count and sum registers, search walk, result register
// depends on lss_pkg, lss_if; drives the store in lss_mem
`default_nettype none

module lss_ctrl
   import lss_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   lss_req_if.sink                req_bus,
   lss_rsp_if.source              rsp_bus,
   output      mem_req_type       mem_req,
   input  wire logic [DATA_W-1:0] mem_rdata
);

   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0]  sum_ff, sum_in;
   op_type             op_ff, op_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   status_type         stat_ff, stat_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic               found_ff, found_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_found_ff;
   logic [8:0]         rsp_count_ff;
   logic [DATA_W-1:0]  rsp_sum_ff;

   logic               req_beat;
   logic               out_free;
   logic               load_rsp;
   logic [COUNT_W-1:0] count_dec;

   assign req_beat  = req_bus.valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign load_rsp  = (state_ff == ST_DONE) && out_free;
   assign count_dec = count_ff - COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      idx_ff   <= idx_in;
      stat_ff  <= stat_in;
      data_ff  <= data_in;
      found_ff <= found_in;
      if (load_rsp) begin
         rsp_status_ff <= stat_ff;
         rsp_data_ff   <= data_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= 9'(count_ff);
         rsp_sum_ff    <= sum_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      op_in    = op_ff;
      val_in   = val_ff;
      idx_in   = idx_ff;
      stat_in  = stat_ff;
      data_in  = data_ff;
      found_in = found_ff;
      mem_req  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               op_in    = req_bus.opcode;
               val_in   = req_bus.value;
               stat_in  = STAT_OK;
               data_in  = '0;
               found_in = 1'b0;
               state_in = ST_DONE;
               case (req_bus.opcode)
                  OP_PUSH: begin
                     if (count_ff == COUNT_W'(STACK_DEPTH)) begin
                        stat_in = STAT_FULL;
                     end else begin
                        mem_req.wr_en = 1'b1;
                        mem_req.addr  = MAX_ADDR_W'(count_ff[ADDR_W-1:0]);
                        mem_req.wdata = req_bus.value;
                        count_in      = count_ff + COUNT_W'(1);
                        sum_in        = sum_ff + req_bus.value;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (count_ff == '0) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = MAX_ADDR_W'(count_dec[ADDR_W-1:0]);
                        state_in      = ST_READ;
                     end
                  end
                  OP_SEARCH: begin
                     // walk starts at the top entry
                     if (count_ff != '0) begin
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = MAX_ADDR_W'(count_dec[ADDR_W-1:0]);
                        idx_in        = count_dec[ADDR_W-1:0];
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            data_in = mem_rdata;
            if (op_ff == OP_POP) begin
               count_in = count_dec;
               sum_in   = sum_ff - mem_rdata;
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // read data belongs to idx_ff; next read issued one below
            if (mem_rdata == val_ff) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (idx_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               mem_req.rd_en = 1'b1;
               mem_req.addr  = MAX_ADDR_W'(idx_ff - ADDR_W'(1));
               idx_in        = idx_ff - ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.data_out    = rsp_data_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.entry_sum   = rsp_sum_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lss_checker.sv @@
// lss_checker: port-level checks of the lifo stack, bound to the top level
// depends on lss_pkg
`default_nettype none

module lss_checker
   import lss_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_data_out,
   input wire logic        rsp_found,
   input wire logic [8:0]  rsp_entry_count,
   input wire logic [31:0] rsp_entry_sum
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_data_out) && $stable(rsp_found) && $stable(rsp_entry_count) &&
      $stable(rsp_entry_sum))
      else $error("result beat changed while stalled");

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_beat)
      else $error("two request beats back to back");

   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_data_out == '0 && !rsp_found)
      else $error("refused request carries data or found");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STAT_OK && rsp_data_out == '0)
      else $error("found set with bad status or data");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_data_out    (rsp_bus.data_out),
   .rsp_found       (rsp_bus.found),
   .rsp_entry_count (rsp_bus.entry_count),
   .rsp_entry_sum   (rsp_bus.entry_sum)
);

`default_nettype wire

@@ test/tb_lifo_stack_with_search.sv @@
// tb_lifo_stack_with_search: self-checking testbench of the lifo stack with search
// drives push, pop, peek and search beats with random bursts and checks every result beat
// depends on lss_pkg, lss_if and lifo_stack_with_search
module tb_lifo_stack_with_search;
   import lss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
   localparam int ITEM_TARGET = 1300;

   typedef struct {
      op_type      op;
      logic [31:0] value;
   } stack_op_type;

   typedef struct {
      status_type  status;
      logic [31:0] data;
      logic        found;
      logic [8:0]  count;
      logic [31:0] sum;
   } stack_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lss_req_if req_bus ();
   lss_rsp_if rsp_bus ();

   lifo_stack_with_search #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   stack_op_type     op_backlog[$];
   stack_result_type pending_results[$];
   logic [31:0]      plan_words[$];   // stack contents as seen by the stimulus generator
   int               mismatch_count = 0;

   // predicted stack state
   logic [31:0] model_words[STACK_DEPTH];
   int          model_depth = 0;
   logic [31:0] model_sum = '0;

   // ---------------- prediction ----------------
   task automatic apply_stack_op(input stack_op_type item);
      stack_result_type r;
      r.status = STAT_OK;
      r.data   = '0;
      r.found  = 1'b0;
      case (item.op)
         OP_PUSH: begin
            if (model_depth >= STACK_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               model_words[model_depth] = item.value;
               model_depth++;
               model_sum += item.value;
            end
         end
         OP_POP: begin
            if (model_depth == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               model_depth--;
               r.data = model_words[model_depth];
               model_sum -= r.data;
            end
         end
         OP_PEEK: begin
            if (model_depth == 0) r.status = STAT_EMPTY;
            else r.data = model_words[model_depth-1];
         end
         default: begin
            for (int i = 0; i < model_depth; i++)
               if (model_words[i] == item.value) r.found = 1'b1;
         end
      endcase
      r.count = 9'(model_depth);
      r.sum   = model_sum;
      pending_results.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------- stimulus generation ----------------
   task automatic add_op(input op_type op, input logic [31:0] value);
      stack_op_type item;
      item.op    = op;
      item.value = value;
      op_backlog.push_back(item);
      if (op == OP_PUSH && plan_words.size() < STACK_DEPTH) plan_words.push_back(value);
      if (op == OP_POP && plan_words.size() > 0) void'(plan_words.pop_back());
   endtask

   function automatic logic [31:0] rand_word();
      logic [3:0] nib;
      nib = 4'($urandom);
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3:    return {{28{nib[3]}}, nib};   // small values, so duplicates show up
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] search_key();
      if (plan_words.size() > 0 && $urandom_range(0, 1) == 0)
         return plan_words[$urandom_range(0, plan_words.size() - 1)];
      return rand_word();
   endfunction

   // ---------------- driver ----------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 0;
         gap_left      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_stack_op(op_backlog[0]);
            void'(op_backlog.pop_front());
         end
         if (req_bus.valid && !req_bus.ready) begin
            // beat still offered, hold it
         end else if (gap_left > 0) begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (op_backlog.size() > 0) begin
            req_bus.valid  <= 1'b1;
            req_bus.opcode <= op_backlog[0].op;
            req_bus.value  <= op_backlog[0].value;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------- receiver ----------------
   int rx_cycle = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_cycle      <= 0;
         hold_left     <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (rx_cycle == 1500 || rx_cycle == 30000) begin
            // long hold-off so the request side backs up
            hold_left     <= 400;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 700) % 3)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin : check_rsp
      stack_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("data_out", want.data, rsp_bus.data_out);
            check_field("found", 32'(want.found), 32'(rsp_bus.found));
            check_field("entry_count", 32'(want.count), 32'(rsp_bus.entry_count));
            check_field("entry_sum", want.sum, rsp_bus.entry_sum);
         end
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      int roll;
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_PUSH;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;

      // empty stack, extreme words, duplicates and wrapping sum
      add_op(OP_POP, 32'h0);
      add_op(OP_PEEK, 32'h0);
      add_op(OP_SEARCH, 32'h0);
      add_op(OP_PUSH, 32'h7fff_ffff);
      add_op(OP_PUSH, 32'h8000_0000);
      add_op(OP_PUSH, 32'h0);
      add_op(OP_PUSH, 32'hffff_ffff);
      add_op(OP_PEEK, 32'h0);
      add_op(OP_SEARCH, 32'h8000_0000);
      add_op(OP_SEARCH, 32'h1234_5678);
      add_op(OP_SEARCH, 32'hffff_ffff);
      add_op(OP_PUSH, 32'h7fff_ffff);
      add_op(OP_SEARCH, 32'h7fff_ffff);
      for (int i = 0; i < 6; i++) add_op(OP_POP, 32'h0);
      add_op(OP_PEEK, 32'h0);
      add_op(OP_SEARCH, 32'h7fff_ffff);

      // fill to the top, push into a full stack, then drain
      while (plan_words.size() < STACK_DEPTH) add_op(OP_PUSH, $urandom);
      for (int i = 0; i < 3; i++) add_op(OP_PUSH, rand_word());
      add_op(OP_SEARCH, plan_words[0]);
      add_op(OP_SEARCH, 32'h5a5a_5a5a);
      add_op(OP_PEEK, 32'h0);
      while (plan_words.size() > 0) begin
         if (plan_words.size() % 32 == 0) add_op(OP_SEARCH, search_key());
         if (plan_words.size() % 9 == 0) add_op(OP_PEEK, 32'h0);
         add_op(OP_POP, 32'h0);
      end
      add_op(OP_POP, 32'h0);

      // random walk, kept shallow so searches stay short
      while (op_backlog.size() < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (plan_words.size() == 0) begin
            if (roll < 60) add_op(OP_PUSH, rand_word());
            else if (roll < 75) add_op(OP_POP, rand_word());
            else if (roll < 88) add_op(OP_PEEK, rand_word());
            else add_op(OP_SEARCH, rand_word());
         end else begin
            if (roll < (plan_words.size() > 48 ? 20 : 40)) add_op(OP_PUSH, rand_word());
            else if (roll < 70) add_op(OP_POP, rand_word());
            else if (roll < 82) add_op(OP_PEEK, rand_word());
            else add_op(OP_SEARCH, search_key());
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() > 0 || req_bus.valid || pending_results.size() > 0)
         @(negedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_lifo_stack_with_search: PASS");
      end else begin
         $display("tb_lifo_stack_with_search: FAIL");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("tb_lifo_stack_with_search: FAIL");
      $finish;
   end

endmodule

@@ lifo_stack_with_search.f @@
hw/rtl/lss_pkg.sv
hw/rtl/lss_if.sv
hw/rtl/lss_mem.sv
hw/rtl/lss_ctrl.sv
hw/rtl/lifo_stack_with_search.sv
hw/rtl/lss_checker.sv
test/tb_lifo_stack_with_search.sv
